/* rtl/core/mcw_pkg.sv */
package mcw_pkg;

  // Store sizes and letter alphabet
  localparam int MAX_TEXT    = 65536;
  localparam int MAX_PATTERN = 65535;
  localparam int LETTERS     = 52;
  localparam int HALF        = 26;

  localparam int TEXT_AW  = $clog2(MAX_TEXT);
  localparam int CNT_W    = TEXT_AW + 1;
  localparam int NEED_W   = $clog2(MAX_PATTERN + 1);
  localparam int CODE_W   = $clog2(LETTERS);
  localparam int DEF_W    = 18;
  localparam int SYM_W    = 8;
  localparam int START_W  = 16;
  localparam int LENGTH_W = 17;

  localparam logic [SYM_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [SYM_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [SYM_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [SYM_W-1:0] CHAR_LOWER_Z = 8'h7A;

  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_TEXT    = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT,
    ST_TXT,
    ST_LOOK,
    ST_FIX,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic             req_type;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } item_t;

  typedef struct packed {
    logic                found;
    logic [START_W-1:0]  start_res;
    logic [LENGTH_W-1:0] length;
    logic                overflow;
  } result_t;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
  } letter_t;

  // Deficit table access, one read and one write port
  typedef struct packed {
    logic              rd_en;
    logic [CODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [CODE_W-1:0] wr_addr;
    logic [DEF_W-1:0]  wr_data;
    logic              clear;
  } def_req_t;

  // Text store access
  typedef struct packed {
    logic               rd_en;
    logic [TEXT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [TEXT_AW-1:0] wr_addr;
    logic [CODE_W-1:0]  wr_data;
  } txt_req_t;

  typedef struct packed {
    logic              busy;
    logic [CNT_W-1:0]  ws;
    logic [CNT_W-1:0]  tc;
    logic [NEED_W-1:0] need;
  } ctl_status_t;

  // Map an ASCII byte to a letter code: upper case first, then lower case
  function automatic letter_t letter_code(input logic [SYM_W-1:0] b);
    letter_t r;
    r.ok   = 1'b0;
    r.code = '0;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r.ok   = 1'b1;
      r.code = CODE_W'(b - CHAR_UPPER_A);
    end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      r.ok   = 1'b1;
      r.code = CODE_W'(b - CHAR_LOWER_A + SYM_W'(HALF));
    end
    return r;
  endfunction

endpackage

/* rtl/core/mcw_def_mem.sv */
module mcw_def_mem import mcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  def_req_t         req,
  output logic [DEF_W-1:0] rd_data
);

  logic [DEF_W-1:0]   mem [LETTERS];
  logic [LETTERS-1:0] valid;
  logic [DEF_W-1:0]   mem_q;
  logic               hit_q;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  // Entry valid bits; a clear drops the whole table at once
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else if (req.rd_en) begin
      hit_q <= valid[req.rd_addr];
    end
  end

  // Unwritten entries read as zero
  assign rd_data = hit_q ? mem_q : '0;

endmodule

/* rtl/core/mcw_text_mem.sv */
module mcw_text_mem import mcw_pkg::*; (
  input  logic              clk,
  input  txt_req_t          req,
  output logic [CODE_W-1:0] rd_data
);

  logic [CODE_W-1:0] mem [MAX_TEXT];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* rtl/core/mcw_ctrl.sv */
module mcw_ctrl import mcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  item_t             item,
  input  logic              slot_free,
  input  logic [DEF_W-1:0]  def_rd,
  input  logic [CODE_W-1:0] txt_rd,
  output def_req_t          def_req,
  output txt_req_t          txt_req,
  output logic              report,
  output result_t           res,
  output ctl_status_t       status
);

  state_t            state;
  state_t            state_next;
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  ws;
  logic [CNT_W-1:0]  tc;
  logic              best_found;
  logic [CNT_W-1:0]  best_start;
  logic [CNT_W-1:0]  best_len;
  logic              ovf;
  logic [CODE_W-1:0] cur;
  logic              pend_last;

  letter_t           lc;
  logic              is_text;
  logic              tc_full;
  logic              pre_rec;
  logic [DEF_W-1:0]  dp;
  logic [DEF_W-1:0]  dn;
  logic              dp_pos;
  logic              dn_nonneg;
  logic              pat_room;
  logic [NEED_W-1:0] need_txt;
  logic [NEED_W-1:0] need_fix;
  logic [CNT_W-1:0]  ws_inc;
  logic [CNT_W-1:0]  win_len;
  logic              better;
  logic [CODE_W-1:0] txt_code;

  // Decode the incoming beat and the value read back from the deficit table
  always_comb begin
    lc        = letter_code(item.symbol);
    is_text   = (item.req_type == REQ_TEXT);
    tc_full   = (tc >= CNT_W'(MAX_TEXT));
    pre_rec   = is_text && (need == '0) && !best_found;
    dp        = def_rd + DEF_W'(1);
    dn        = def_rd - DEF_W'(1);
    dp_pos    = !dp[DEF_W-1] && (dp != '0);
    dn_nonneg = !dn[DEF_W-1];
    pat_room  = (need < NEED_W'(MAX_PATTERN));
    need_txt  = (dn_nonneg && need != '0) ? need - NEED_W'(1) : need;
    need_fix  = dp_pos ? need + NEED_W'(1) : need;
    ws_inc    = ws + CNT_W'(1);
    win_len   = tc - ws;
    better    = !best_found || (win_len < best_len);
    txt_code  = (txt_rd >= CODE_W'(LETTERS)) ? '0 : txt_rd;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (!is_text) begin
            state_next = lc.ok ? ST_PAT : ST_IDLE;
          end else if (lc.ok && !tc_full) begin
            state_next = ST_TXT;
          end else if (item.last) begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_PAT: state_next = ST_IDLE;
      ST_TXT: begin
        if (need_txt == '0 && ws < tc) begin
          state_next = ST_LOOK;
        end else begin
          state_next = pend_last ? ST_REPORT : ST_IDLE;
        end
      end
      ST_LOOK: state_next = ST_FIX;
      ST_FIX: begin
        if (need_fix == '0 && ws_inc < tc) begin
          state_next = ST_LOOK;
        end else begin
          state_next = pend_last ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory requests and result strobe
  always_comb begin
    def_req = '0;
    txt_req = '0;
    report  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid && lc.ok && (!is_text || !tc_full)) begin
          def_req.rd_en   = 1'b1;
          def_req.rd_addr = lc.code;
          if (is_text) begin
            txt_req.wr_en   = 1'b1;
            txt_req.wr_addr = tc[TEXT_AW-1:0];
            txt_req.wr_data = lc.code;
          end
        end
      end
      ST_PAT: begin
        if (!dp_pos || pat_room) begin
          def_req.wr_en   = 1'b1;
          def_req.wr_addr = cur;
          def_req.wr_data = dp;
        end
      end
      ST_TXT: begin
        def_req.wr_en   = 1'b1;
        def_req.wr_addr = cur;
        def_req.wr_data = dn;
        txt_req.rd_en   = 1'b1;
        txt_req.rd_addr = ws[TEXT_AW-1:0];
      end
      ST_LOOK: begin
        def_req.rd_en   = 1'b1;
        def_req.rd_addr = txt_code;
        // prefetch the next window letter
        txt_req.rd_en   = 1'b1;
        txt_req.rd_addr = ws_inc[TEXT_AW-1:0];
      end
      ST_FIX: begin
        def_req.wr_en   = 1'b1;
        def_req.wr_addr = cur;
        def_req.wr_data = dp;
      end
      ST_REPORT: begin
        if (slot_free) begin
          report        = 1'b1;
          def_req.clear = 1'b1;
        end
      end
      default: begin
        report = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters, best window and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      need       <= '0;
      ws         <= '0;
      tc         <= '0;
      best_found <= 1'b0;
      best_start <= '0;
      best_len   <= '0;
      ovf        <= 1'b0;
      pend_last  <= 1'b0;
      cur        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            pend_last <= item.last;
            cur       <= lc.code;
            // empty pattern: the empty window covers it
            if (pre_rec) begin
              best_found <= 1'b1;
              best_start <= ws;
              best_len   <= '0;
            end
            if (is_text && lc.ok) begin
              if (tc_full) begin
                ovf <= 1'b1;
              end else begin
                tc <= tc + CNT_W'(1);
              end
            end
          end
        end
        ST_PAT: begin
          if (dp_pos) begin
            if (pat_room) begin
              need <= need + NEED_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        ST_TXT: begin
          need <= need_txt;
        end
        ST_LOOK: begin
          cur <= txt_code;
        end
        ST_FIX: begin
          need <= need_fix;
          ws   <= ws_inc;
          if (better) begin
            best_found <= 1'b1;
            best_start <= ws;
            best_len   <= win_len;
          end
        end
        ST_REPORT: begin
          if (slot_free) begin
            need       <= '0;
            ws         <= '0;
            tc         <= '0;
            best_found <= 1'b0;
            best_start <= '0;
            best_len   <= '0;
            ovf        <= 1'b0;
          end
        end
        default: begin
          pend_last <= 1'b0;
        end
      endcase
    end
  end

  // Result payload; start and length zeroed when nothing was found
  always_comb begin
    res.found     = best_found;
    res.start_res = best_found ? START_W'(best_start) : '0;
    res.length    = best_found ? LENGTH_W'(best_len) : '0;
    res.overflow  = ovf;
  end

  always_comb begin
    status.busy = (state != ST_IDLE);
    status.ws   = ws;
    status.tc   = tc;
    status.need = need;
  end

endmodule

/* rtl/core/minimum_covering_window.sv */
// Channel  Payload   Handshake                 Direction
// item     item_t    item_valid / item_stall   in:  pattern or text letter, last mark
// result   result_t  result_valid / result_stall  out: found, start, length, overflow
//
// Steps: a non-letter beat is taken straight from idle, a pattern or text letter adds a
// deficit table update, and each letter dropped from the left of the window adds a deficit
// table read, then write back. A text beat marked last adds a report step, held while the
// result register holds an untaken beat.
// Reset: synchronous; deficit table valid bits clear at once, no clearing pass.
// Stalls: a new item is taken while a result waits; only the next result waits for it.
module minimum_covering_window import mcw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  def_req_t          def_req;
  txt_req_t          txt_req;
  logic [DEF_W-1:0]  def_rd;
  logic [CODE_W-1:0] txt_rd;
  logic              report;
  result_t           res;
  ctl_status_t       status;
  logic              slot_free;

  assign slot_free  = !result_valid || !result_stall;
  assign item_stall = status.busy;

  mcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .def_rd     (def_rd),
    .txt_rd     (txt_rd),
    .def_req    (def_req),
    .txt_req    (txt_req),
    .report     (report),
    .res        (res),
    .status     (status)
  );

  mcw_def_mem u_def_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (def_req),
    .rd_data (def_rd)
  );

  mcw_text_mem u_text_mem (
    .clk     (clk),
    .req     (txt_req),
    .rd_data (txt_rd)
  );

  // Output register: load on report, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (report) begin
      result_valid <= 1'b1;
    end else if (result_stall == 1'b0) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      result <= res;
    end
  end

  a_report_slot: assert property (@(posedge clk) disable iff (rst)
    report |-> (!result_valid || !result_stall))
    else $error("result loaded over an untaken beat");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    status.ws <= status.tc)
    else $error("window start passed text count");

  a_text_bound: assert property (@(posedge clk) disable iff (rst)
    status.tc <= CNT_W'(MAX_TEXT))
    else $error("text count beyond store size");

  a_job_clear: assert property (@(posedge clk) disable iff (rst)
    report |=> (status.tc == '0 && status.ws == '0 && status.need == '0))
    else $error("job state not cleared after result");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mcw_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  minimum_covering_window dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up after a generous bound on the slowest correct run
  initial begin
    #50_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Window tracker state, mirrors the block's tables
  longint     shortage [LETTERS];
  logic [5:0] text_mem [MAX_TEXT];
  int         need_cnt  = 0;
  int         win_lo    = 0;
  int         txt_cnt   = 0;
  bit         best_ok   = 1'b0;
  int         best_at   = 0;
  int         best_len  = 0;
  bit         ovf_seen  = 1'b0;

  result_t    pending_windows [$];
  int         miss_cnt     = 0;
  int         letters_fed  = 0;
  bit         tx_idle      = 1'b1;
  bit         rx_idle      = 1'b1;
  int         rx_hold      = 0;

  initial foreach (shortage[i]) shortage[i] = 0;

  function automatic int letter_of(logic [7:0] b);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return int'(b - CHAR_UPPER_A);
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) return HALF + int'(b - CHAR_LOWER_A);
    return -1;
  endfunction

  function automatic logic [7:0] glyph_of(int c);
    if (c < HALF) return CHAR_UPPER_A + 8'(c);
    return CHAR_LOWER_A + 8'(c - HALF);
  endfunction

  function automatic item_t make_item(req_t kind, logic [7:0] sym, logic fin);
    item_t it;
    it.req_type = kind;
    it.symbol   = sym;
    it.last     = fin;
    return it;
  endfunction

  // Keep the first window of the shortest length
  function automatic void note_window(int at, int len);
    if (!best_ok || len < best_len) begin
      best_ok  = 1'b1;
      best_at  = at;
      best_len = len;
    end
  endfunction

  // Advance the window tracker by one beat; emit is set on a job's last text beat
  task automatic track_window(input item_t it, output bit emit, output result_t r);
    int code;
    int c;
    emit = 1'b0;
    r    = '0;
    code = letter_of(it.symbol);
    if (it.req_type == REQ_PATTERN) begin
      if (code >= 0) begin
        if (shortage[code] + 1 > 0 && need_cnt >= MAX_PATTERN) begin
          ovf_seen = 1'b1;
        end else begin
          if (shortage[code] + 1 > 0) need_cnt++;
          shortage[code]++;
        end
      end
      return;
    end
    if (need_cnt == 0 && !best_ok) note_window(win_lo, 0);
    if (code >= 0) begin
      if (txt_cnt >= MAX_TEXT) begin
        ovf_seen = 1'b1;
      end else begin
        text_mem[txt_cnt] = 6'(code);
        txt_cnt++;
        shortage[code]--;
        if (shortage[code] >= 0 && need_cnt > 0) need_cnt--;
        // shrink from the left while the pattern stays covered
        while (need_cnt == 0 && win_lo < txt_cnt) begin
          note_window(win_lo, txt_cnt - win_lo);
          c = text_mem[win_lo];
          shortage[c]++;
          if (shortage[c] > 0) need_cnt++;
          win_lo++;
        end
      end
    end
    if (!it.last) return;
    emit        = 1'b1;
    r.found     = best_ok;
    r.start_res = best_ok ? best_at[START_W-1:0] : '0;
    r.length    = best_ok ? best_len[LENGTH_W-1:0] : '0;
    r.overflow  = ovf_seen;
    foreach (shortage[i]) shortage[i] = 0;
    need_cnt = 0;
    win_lo   = 0;
    txt_cnt  = 0;
    best_ok  = 1'b0;
    best_at  = 0;
    best_len = 0;
    ovf_seen = 1'b0;
  endtask

  // Drive one beat, wait for the handshake, then queue what it should produce
  task automatic feed(input item_t it, input bit typed = 1'b0, input result_t want = '0);
    bit      emit;
    result_t r;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    track_window(it, emit, r);
    if (emit) pending_windows.push_back(typed ? want : r);
    if (letter_of(it.symbol) >= 0 || (it.req_type == REQ_TEXT && it.last)) letters_fed++;
  endtask

  // Hold the sender off until every queued result has arrived
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() > 0) @(posedge clk);
  endtask

  // One job: mostly a pattern then text over a small alphabet, sometimes noise
  task automatic run_job();
    int         k;
    int         plen;
    int         tlen;
    int         r;
    logic [7:0] pick [5];
    logic [7:0] sym;
    k = $urandom_range(1, 5);
    for (int i = 0; i < k; i++) pick[i] = glyph_of($urandom_range(0, LETTERS - 1));
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1) == 0)
          feed(make_item(REQ_PATTERN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        else
          feed(make_item(REQ_TEXT, 8'($urandom_range(0, 255)), 1'b0));
      end
    end else begin
      plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      repeat (plen) begin
        sym = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : pick[$urandom_range(0, k - 1)];
        feed(make_item(REQ_PATTERN, sym, ($urandom_range(0, 7) == 0)));
      end
      tlen = $urandom_range(1, 30);
      repeat (tlen - 1) begin
        r = $urandom_range(0, 19);
        if (r < 16)
          feed(make_item(REQ_TEXT, pick[$urandom_range(0, k - 1)], 1'b0));
        else if (r < 18)
          feed(make_item(REQ_TEXT, 8'($urandom_range(0, 255)), 1'b0));
        else if (r == 18)
          feed(make_item(REQ_TEXT, glyph_of($urandom_range(0, LETTERS - 1)), 1'b0));
        else
          feed(make_item(REQ_PATTERN, pick[$urandom_range(0, k - 1)], 1'b0));
      end
    end
    sym = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                      : pick[$urandom_range(0, k - 1)];
    feed(make_item(REQ_TEXT, sym, 1'b1));
  endtask

  // Directed beats; typed results are the ones evident by inspection
  typedef struct {
    req_t       kind;
    logic [7:0] sym;
    logic       fin;
    bit         typed;
    result_t    want;
  } plan_row_t;

  localparam int      PLAN_N = 25;
  localparam result_t NO_RES = '0;

  plan_row_t plan [PLAN_N] = '{
    // empty pattern: zero-length window at the start
    '{REQ_TEXT,    "a",   1'b1, 1'b1, '{1'b1, 16'd0, 17'd0, 1'b0}},
    // last on a pattern beat is ignored; non-letters dropped
    '{REQ_PATTERN, "A",   1'b1, 1'b0, NO_RES},
    '{REQ_PATTERN, "Z",   1'b0, 1'b0, NO_RES},
    '{REQ_PATTERN, "z",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    8'h30, 1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    8'hFF, 1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    8'h00, 1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "A",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "z",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "Z",   1'b1, 1'b1, '{1'b1, 16'd0, 17'd3, 1'b0}},
    // nothing found
    '{REQ_PATTERN, "q",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "r",   1'b1, 1'b1, '{1'b0, 16'd0, 17'd0, 1'b0}},
    // bytes just outside the letter ranges, last on a non-letter
    '{REQ_PATTERN, "b",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "b",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    8'h5B, 1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    8'h60, 1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    8'h7B, 1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    8'h40, 1'b1, 1'b1, '{1'b1, 16'd0, 17'd1, 1'b0}},
    // pattern letter after text
    '{REQ_TEXT,    "c",   1'b0, 1'b0, NO_RES},
    '{REQ_PATTERN, "c",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "c",   1'b1, 1'b0, NO_RES},
    // equal lengths: the first window wins
    '{REQ_PATTERN, "x",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "x",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "y",   1'b0, 1'b0, NO_RES},
    '{REQ_TEXT,    "x",   1'b1, 1'b1, '{1'b1, 16'd0, 17'd1, 1'b0}}
  };

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (rx_hold == 0 && rx_idle && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 15);
    if (rx_hold > 0) begin
      rx_hold--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expected window
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_windows.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= 10)
          $display("unexpected result: found=%0d start=%0d len=%0d ovf=%0d",
                   result.found, result.start_res, result.length, result.overflow);
      end else begin
        want = pending_windows.pop_front();
        if (result.found !== want.found || result.start_res !== want.start_res ||
            result.length !== want.length || result.overflow !== want.overflow) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display({"window mismatch: exp found=%0d start=%0d len=%0d ovf=%0d, ",
                      "got found=%0d start=%0d len=%0d ovf=%0d"},
                     want.found, want.start_res, want.length, want.overflow,
                     result.found, result.start_res, result.length, result.overflow);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) feed(make_item(plan[i].kind, plan[i].sym, plan[i].fin),
                           plan[i].typed, plan[i].want);
    drain();

    // random jobs with idling on both sides
    tx_idle     = 1'b1;
    letters_fed = 0;
    while (letters_fed < 500) begin
      run_job();
      if ($urandom_range(0, 9) == 0) drain();
    end

    // closing stretch at full rate
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (letters_fed < 600) run_job();

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (miss_cnt == 0 && pending_windows.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
